// ----- rtl/jcfc_pkg.sv -----
// Shared types, phase codes and word tables for the JSON category field classifier.
package jcfc_pkg;

  // Parse phase codes.
  localparam logic [2:0] PH_KEY   = 3'd0;
  localparam logic [2:0] PH_COLON = 3'd1;
  localparam logic [2:0] PH_WS    = 3'd2;
  localparam logic [2:0] PH_STR   = 3'd3;
  localparam logic [2:0] PH_ESC   = 3'd4;
  localparam logic [2:0] PH_DONE  = 3'd5;
  localparam logic [2:0] PH_FAIL  = 3'd6;

  // Category codes.
  localparam logic [1:0] CAT_UNKNOWN = 2'd0;
  localparam logic [1:0] CAT_DETECT  = 2'd1;
  localparam logic [1:0] CAT_DRAIN   = 2'd2;
  localparam logic [1:0] CAT_DIAG    = 2'd3;

  localparam logic [3:0] LEN_MAX      = 4'd15;
  localparam logic [3:0] LEN_LONG_WRD = 4'd9;
  localparam logic [3:0] LEN_DIAG     = 4'd4;
  localparam logic [2:0] KEY_LAST     = 3'd4;

  // Candidate bit positions.
  localparam int unsigned CAND_DET = 0;
  localparam int unsigned CAND_DRN = 1;
  localparam int unsigned CAND_DIA = 2;

  typedef struct packed {
    logic [2:0] phase;
    logic [2:0] key_pos;
    logic [3:0] len;
    logic [2:0] alive;
  } jcfc_state_t;

  localparam jcfc_state_t STATE_RESET = '{
    phase:   PH_KEY,
    key_pos: 3'd0,
    len:     4'd0,
    alive:   3'b111
  };

  // Bytes of the quoted key "cat".
  function automatic logic [7:0] key_char(input logic [2:0] k);
    logic [7:0] c;
    case (k)
      3'd0:    c = 8'h22;
      3'd1:    c = 8'h63;
      3'd2:    c = 8'h61;
      3'd3:    c = 8'h74;
      default: c = 8'h22;
    endcase
    return c;
  endfunction

  // "Detection"; positions past the word never match.
  function automatic logic det_hit(input logic [3:0] n, input logic [7:0] ch);
    logic [7:0] c;
    logic       ok;
    ok = 1'b1;
    case (n)
      4'd0:    c = 8'h44;
      4'd1:    c = 8'h65;
      4'd2:    c = 8'h74;
      4'd3:    c = 8'h65;
      4'd4:    c = 8'h63;
      4'd5:    c = 8'h74;
      4'd6:    c = 8'h69;
      4'd7:    c = 8'h6f;
      4'd8:    c = 8'h6e;
      default: begin
        c  = 8'h00;
        ok = 1'b0;
      end
    endcase
    return ok && (c == ch);
  endfunction

  // "drain-ack".
  function automatic logic drn_hit(input logic [3:0] n, input logic [7:0] ch);
    logic [7:0] c;
    logic       ok;
    ok = 1'b1;
    case (n)
      4'd0:    c = 8'h64;
      4'd1:    c = 8'h72;
      4'd2:    c = 8'h61;
      4'd3:    c = 8'h69;
      4'd4:    c = 8'h6e;
      4'd5:    c = 8'h2d;
      4'd6:    c = 8'h61;
      4'd7:    c = 8'h63;
      4'd8:    c = 8'h6b;
      default: begin
        c  = 8'h00;
        ok = 1'b0;
      end
    endcase
    return ok && (c == ch);
  endfunction

  // "diag".
  function automatic logic dia_hit(input logic [3:0] n, input logic [7:0] ch);
    logic [7:0] c;
    logic       ok;
    ok = 1'b1;
    case (n)
      4'd0:    c = 8'h64;
      4'd1:    c = 8'h69;
      4'd2:    c = 8'h61;
      4'd3:    c = 8'h67;
      default: begin
        c  = 8'h00;
        ok = 1'b0;
      end
    endcase
    return ok && (c == ch);
  endfunction

  // Category from a state after its byte has been taken.
  function automatic logic [1:0] category(input jcfc_state_t st);
    logic [1:0] cat;
    cat = CAT_UNKNOWN;
    if (st.phase == PH_DONE) begin
      if (st.alive[CAND_DET] && st.len == LEN_LONG_WRD) begin
        cat = CAT_DETECT;
      end else if (st.alive[CAND_DRN] && st.len == LEN_LONG_WRD) begin
        cat = CAT_DRAIN;
      end else if (st.alive[CAND_DIA] && st.len == LEN_DIAG) begin
        cat = CAT_DIAG;
      end
    end
    return cat;
  endfunction

endpackage

// ----- rtl/json_category_field_classifier.sv -----
// Top level of the JSON category field classifier: input register, parser state, result register.
//
//  Channel | Handshake                    | Payload
//  --------+------------------------------+------------------------------
//  in      | in_valid_i / in_stall_o      | payload_byte_i, final_byte_i
//  out     | out_valid_o / out_stall_i    | category_kind_o
//
// One byte per cycle is taken while in_stall_o is low; a byte is held in the input
// register while its state update settles in combinational logic, and a final byte's
// result is loaded into the result register. Reset puts the parser in its key search
// state and empties both registers. A stalled result holds the output
// register; only a final byte waiting behind it is held, other bytes flow on.
module json_category_field_classifier (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] payload_byte_i,
  input  logic       final_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] category_kind_o
);
  import jcfc_pkg::*;

  logic        in_valid_q;
  logic [7:0]  byte_q;
  logic        final_q;
  jcfc_state_t state_q, state_d, state_step;
  logic        out_valid_q;
  logic [1:0]  cat_q;
  logic        out_free;
  logic        hold;
  logic        fire;

  jcfc_step u_step (
    .state_i (state_q),
    .byte_i  (byte_q),
    .state_o (state_step)
  );

  // A final byte waits only when the result register is occupied and stalled.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign hold       = in_valid_q && final_q && !out_free;
  assign fire       = in_valid_q && !hold;
  assign in_stall_o = hold;

  // A final byte reports the category and returns the parser to reset.
  assign state_d = (fire && final_q) ? STATE_RESET : (fire ? state_step : state_q);

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!hold) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!hold && in_valid_i) begin
      byte_q  <= payload_byte_i;
      final_q <= final_byte_i;
    end
  end

  // Parser state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_RESET;
    end else begin
      state_q <= state_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= fire && final_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && fire && final_q) begin
      cat_q <= category(state_step);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign category_kind_o = cat_q;

endmodule

// ----- rtl/jcfc_word_match.sv -----
// Compares one decoded character against the three category words and counts length.
module jcfc_word_match (
  input  logic [3:0] len_i,
  input  logic [2:0] alive_i,
  input  logic [7:0] char_i,
  output logic [3:0] len_o,
  output logic [2:0] alive_o
);
  import jcfc_pkg::*;

  // A candidate stays alive only while each new character matches its word.
  always_comb begin
    alive_o           = alive_i;
    alive_o[CAND_DET] = alive_i[CAND_DET] & det_hit(len_i, char_i);
    alive_o[CAND_DRN] = alive_i[CAND_DRN] & drn_hit(len_i, char_i);
    alive_o[CAND_DIA] = alive_i[CAND_DIA] & dia_hit(len_i, char_i);
  end

  // The length saturates at its maximum.
  assign len_o = (len_i < LEN_MAX) ? len_i + 4'd1 : len_i;

endmodule

// ----- rtl/jcfc_step.sv -----
// Next-state logic of the parser for one payload byte.
module jcfc_step (
  input  jcfc_pkg::jcfc_state_t state_i,
  input  logic [7:0]            byte_i,
  output jcfc_pkg::jcfc_state_t state_o
);
  import jcfc_pkg::*;

  logic [2:0] k;
  logic       push;
  logic [7:0] push_char;
  logic [3:0] len_next;
  logic [2:0] alive_next;

  jcfc_word_match u_match (
    .len_i   (state_i.len),
    .alive_i (state_i.alive),
    .char_i  (push_char),
    .len_o   (len_next),
    .alive_o (alive_next)
  );

  // Key position above the last key byte restarts the search.
  assign k = (state_i.key_pos > KEY_LAST) ? 3'd0 : state_i.key_pos;

  // Phase transitions and the decoded character to push.
  always_comb begin
    state_o   = state_i;
    push      = 1'b0;
    push_char = byte_i;
    case (state_i.phase)
      PH_KEY: begin
        if (byte_i == key_char(k)) begin
          if (k == KEY_LAST) begin
            state_o.phase   = PH_COLON;
            state_o.key_pos = 3'd0;
          end else begin
            state_o.key_pos = k + 3'd1;
          end
        end else begin
          // A stray quote can itself open the key.
          state_o.key_pos = (byte_i == 8'h22) ? 3'd1 : 3'd0;
        end
      end
      PH_COLON: begin
        if (byte_i == 8'h3a) state_o.phase = PH_WS;
      end
      PH_WS: begin
        if (!(byte_i == 8'h20 || byte_i == 8'h09 || byte_i == 8'h0d ||
              byte_i == 8'h0a)) begin
          state_o.phase = (byte_i == 8'h22) ? PH_STR : PH_FAIL;
        end
      end
      PH_STR: begin
        if (byte_i == 8'h5c) begin
          state_o.phase = PH_ESC;
        end else if (byte_i == 8'h22) begin
          state_o.phase = PH_DONE;
        end else begin
          push = 1'b1;
        end
      end
      PH_ESC: begin
        state_o.phase = PH_STR;
        push          = 1'b1;
        case (byte_i)
          8'h22, 8'h5c, 8'h2f: push_char = byte_i;
          8'h62:               push_char = 8'h08;
          8'h66:               push_char = 8'h0c;
          8'h6e:               push_char = 8'h0a;
          8'h72:               push_char = 8'h0d;
          8'h74:               push_char = 8'h09;
          default: begin
            push          = 1'b0;
            state_o.phase = PH_FAIL;
          end
        endcase
      end
      default: begin
      end
    endcase
    if (push) begin
      state_o.len   = len_next;
      state_o.alive = alive_next;
    end
  end

endmodule
